### design/sensor_to_midi_note_events_unit_macros.svh
// ----------------------------------------------------------------------------
// Sensor to MIDI note events: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_TO_MIDI_NOTE_EVENTS_UNIT_MACROS_SVH
`define SENSOR_TO_MIDI_NOTE_EVENTS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SMNE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("smne check failed");
// next-cycle implication
`define SMNE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("smne check failed");
`else
`define SMNE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMNE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/smne_pkg.sv
// ----------------------------------------------------------------------------
// smne_pkg
// Shared constants and types of the sensor to MIDI note events unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smne_pkg;

    localparam int SENSOR_COUNT = 16;
    localparam int IDX_W        = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] MIN_VELOCITY    = 8'h01;
    localparam logic [6:0] BASE_NOTE_RST   = 7'd36;
    localparam logic [3:0] CHANNEL_RST     = 4'd0;

    // register index, taken from paddr[2]
    localparam logic REG_CHANNEL = 1'b0;
    localparam logic REG_BASE    = 1'b1;

    typedef logic [SENSOR_COUNT-1:0] t_map;

    // one MIDI message with its end-of-run mark
    typedef struct packed {
        logic       last;
        logic [7:0] value;
        logic [7:0] note;
        logic [7:0] status;
    } t_msg;

    // controller to datapath
    typedef struct packed {
        logic accept_upd;
        logic rel_start;
        logic scan_step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic q_full;
        logic cur_on;
        logic map_empty;
        logic upd_hit;
    } t_dp_status;

endpackage

`default_nettype wire

### design/smne_ctrl.sv
// ----------------------------------------------------------------------------
// smne_ctrl
// Controller: takes input beats and sequences the release-all scan.
// ----------------------------------------------------------------------------
`default_nettype none

module smne_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_mode,
    input  wire smne_pkg::t_dp_status  i_status,
    output logic                       o_in_ready,
    output smne_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    // decode commands from state and status
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.accept_upd = 1'b0;
        o_cmd.rel_start  = 1'b0;
        o_cmd.scan_step  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_status.q_full;
                if (i_in_valid && !i_status.q_full) begin
                    if (i_in_mode) begin
                        o_cmd.rel_start = 1'b1;
                        n_state         = ST_SCAN;
                    end else begin
                        o_cmd.accept_upd = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (i_status.map_empty) begin
                    n_state = ST_IDLE;
                end else begin
                    // skip clear bits, hold on a set bit until the queue has room
                    o_cmd.scan_step = !i_status.cur_on || !i_status.q_full;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### design/smne_dpath.sv
// ----------------------------------------------------------------------------
// smne_dpath
// Datapath: sensor bitmap, scan counter, message build and two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module smne_dpath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire smne_pkg::t_dp_cmd     i_cmd,
    input  wire logic [7:0]            i_sensor_id,
    input  wire logic                  i_active,
    input  wire logic [7:0]            i_velocity,
    input  wire logic [3:0]            i_channel,
    input  wire logic [6:0]            i_base_note,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output smne_pkg::t_msg             o_out_msg,
    output smne_pkg::t_dp_status       o_status
);

    smne_pkg::t_map                r_map;
    smne_pkg::t_map                n_map;
    logic [smne_pkg::IDX_W-1:0]    r_scan;
    logic [smne_pkg::IDX_W-1:0]    n_scan;
    smne_pkg::t_msg                r_q0;
    smne_pkg::t_msg                r_q1;
    logic [1:0]                    r_cnt;
    logic [1:0]                    n_cnt;

    logic                          in_range;
    logic [smne_pkg::IDX_W-1:0]    upd_idx;
    logic                          upd_hit;
    smne_pkg::t_map                scan_bit;
    logic                          scan_push;
    logic                          push;
    logic                          pop;
    smne_pkg::t_msg                push_msg;
    logic [7:0]                    upd_vel;

    // decode the update
    assign in_range = {1'b0, i_sensor_id} < 9'(smne_pkg::SENSOR_COUNT);
    assign upd_idx  = i_sensor_id[smne_pkg::IDX_W-1:0];
    assign upd_hit  = in_range && (r_map[upd_idx] != i_active);
    assign upd_vel  = (i_velocity == 8'd0) ? smne_pkg::MIN_VELOCITY : i_velocity;

    assign scan_bit  = smne_pkg::t_map'(1) << r_scan;
    assign scan_push = i_cmd.scan_step && r_map[r_scan];

    assign push = (i_cmd.accept_upd && upd_hit) || scan_push;
    assign pop  = o_out_valid && i_out_ready;

    // build the message being pushed
    always_comb begin
        if (scan_push) begin
            push_msg.status = smne_pkg::STATUS_NOTE_OFF | {4'd0, i_channel};
            push_msg.note   = {1'b0, i_base_note} + 8'(r_scan);
            push_msg.value  = 8'd0;
            // lower set bits are already cleared, so this is the last if none above
            push_msg.last   = (r_map & ~scan_bit) == '0;
        end else begin
            push_msg.status = (i_active ? smne_pkg::STATUS_NOTE_ON
                                        : smne_pkg::STATUS_NOTE_OFF) | {4'd0, i_channel};
            push_msg.note   = {1'b0, i_base_note} + 8'(upd_idx);
            push_msg.value  = i_active ? upd_vel : 8'd0;
            push_msg.last   = 1'b1;
        end
    end

    // advance bitmap and scan index
    always_comb begin
        n_map  = r_map;
        n_scan = r_scan;
        if (i_cmd.rel_start) begin
            n_scan = '0;
        end else if (i_cmd.scan_step) begin
            n_map  = r_map & ~scan_bit;
            n_scan = r_scan + 1'b1;
        end else if (i_cmd.accept_upd && upd_hit) begin
            n_map[upd_idx] = i_active;
        end
    end

    // queue occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '0;
            r_scan <= '0;
            r_cnt  <= 2'd0;
        end else begin
            r_map  <= n_map;
            r_scan <= n_scan;
            r_cnt  <= n_cnt;
        end
    end

    // queue payload: head in q0, shift on pop
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= (push && r_cnt == 2'd1) ? push_msg : r_q1;
        end else if (push && r_cnt == 2'd0) begin
            r_q0 <= push_msg;
        end
        if (push && !pop && r_cnt == 2'd1) begin
            r_q1 <= push_msg;
        end
    end

    assign o_out_valid        = r_cnt != 2'd0;
    assign o_out_msg          = r_q0;
    assign o_status.q_full    = r_cnt == 2'd2;
    assign o_status.cur_on    = r_map[r_scan];
    assign o_status.map_empty = r_map == '0;
    assign o_status.upd_hit   = upd_hit;

endmodule

`default_nettype wire

### design/sensor_to_midi_note_events_unit.sv
// An update that changes a sensor bit queues its message when the item is accepted.
// A release-all item holds off input while the scan steps from index 0 up to the highest
// set sensor; a set bit waits there while the output queue is full.
// Throughput: one update per cycle, or one note-off per cycle, while the queue has room.
// Reset (synchronous, active low) clears all sensor bits, the queue and the scan,
// and sets the channel to 0 and the base note to 36.
// ----------------------------------------------------------------------------
// sensor_to_midi_note_events_unit
// Turns sensor changes and release-all requests into MIDI note-on and note-off messages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_to_midi_note_events_unit_macros.svh"

module sensor_to_midi_note_events_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // sensor_id[7:0], active[8], velocity[16:9]
    input  wire logic        s_axis_tuser,  // mode
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // status_byte[7:0], note_number[15:8],
                                            // data_value[23:16]
    output logic             m_axis_tlast,  // last_of_run
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [3:0]            r_channel;
    logic [6:0]            r_base_note;
    logic                  cfg_wr;
    smne_pkg::t_dp_cmd     cmd;
    smne_pkg::t_dp_status  status;
    smne_pkg::t_msg        out_msg;

    // write configuration on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel   <= smne_pkg::CHANNEL_RST;
            r_base_note <= smne_pkg::BASE_NOTE_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                smne_pkg::REG_CHANNEL: r_channel   <= pwdata[3:0];
                smne_pkg::REG_BASE:    r_base_note <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // read back configuration
    always_comb begin
        case (paddr[2])
            smne_pkg::REG_CHANNEL: prdata = {28'd0, r_channel};
            smne_pkg::REG_BASE:    prdata = {25'd0, r_base_note};
            default:               prdata = 32'd0;
        endcase
    end

    smne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    smne_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sensor_id    (s_axis_tdata[7:0]),
        .i_active       (s_axis_tdata[8]),
        .i_velocity     (s_axis_tdata[16:9]),
        .i_channel      (r_channel),
        .i_base_note    (r_base_note),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_msg      (out_msg),
        .o_status       (status)
    );

    assign m_axis_tdata = {out_msg.value, out_msg.note, out_msg.status};
    assign m_axis_tlast = out_msg.last;

    // a release beat starts the scan, which blocks input in the following cycle
    `SMNE_ASSERT_NXT(a_rel_blocks, i_clk, i_rst_n, cmd.rel_start, !s_axis_tready)
    // an update that changes a bit always leaves a message to send
    `SMNE_ASSERT_NXT(a_upd_emits, i_clk, i_rst_n, cmd.accept_upd && status.upd_hit,
        m_axis_tvalid)
    // input ready is never raised while the queue is full
    `SMNE_ASSERT_IMP(a_ready_room, i_clk, i_rst_n, s_axis_tready, !status.q_full)

endmodule

`default_nettype wire
